// File: hdl/dmi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmi_pkg
// Types and constants shared by the directional movement index block.
// ----------------------------------------------------------------------------
package dmi_pkg;

  localparam int N_W        = 8;
  localparam int CNT_W      = 9;
  localparam int OUT_W      = 23;
  localparam int OUT_FRAC   = 16;
  localparam int PCT_BITS   = OUT_W - OUT_FRAC;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CNT_W-1:0]    COUNT_MAX     = 9'd511;
  localparam logic [N_W-1:0]      RESET_PERIODS = 8'd14;
  localparam logic [PCT_BITS-1:0] PCT_SCALE     = 7'd100;
  localparam logic [OUT_W-1:0]    FULL_SCALE    = 23'd6553600;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIODS   = 1'b0,
    CFG_DIRECTION = 1'b1
  } dmi_cfg_idx_t;

  typedef enum logic [1:0] {
    SER_PLUS  = 2'd0,
    SER_MINUS = 2'd1,
    SER_RANGE = 2'd2
  } dmi_series_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_ACC,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_UPDATE,
    ST_RATIO_GO,
    ST_RATIO_WAIT,
    ST_EMIT
  } dmi_state_t;

endpackage

// File: hdl/dmi_ndiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmi_ndiv
// Bit-serial restoring divider of a wide sum by the 8-bit smoothing length.
// ----------------------------------------------------------------------------
module dmi_ndiv import dmi_pkg::*; #(
  parameter int SUM_W = 56
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [N_W-1:0]   divisor,
  output logic [SUM_W-1:0] quotient,
  output logic             done
);

  localparam int CW = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] acc_r;
  logic [N_W-1:0]   rem_r;
  logic [CW-1:0]    cnt_r;
  logic             done_r;
  logic [N_W:0]     trial;
  logic [N_W:0]     diff;
  logic             ge;
  logic [N_W-1:0]   rem_nxt;

  assign trial   = {rem_r, acc_r[SUM_W-1]};
  assign diff    = trial - {1'b0, divisor};
  assign ge      = trial >= {1'b0, divisor};
  assign rem_nxt = ge ? diff[N_W-1:0] : trial[N_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(SUM_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= dividend;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      acc_r <= {acc_r[SUM_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign quotient = acc_r;
  assign done     = done_r;

endmodule

// File: hdl/dmi_ratio.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmi_ratio
// Bit-serial divider giving floor(100 * 2^16 * movement / range).
// ----------------------------------------------------------------------------
module dmi_ratio import dmi_pkg::*; #(
  parameter int SUM_W = 56
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [SUM_W+PCT_BITS-1:0] scaled_dm,
  input  logic [SUM_W-1:0]          range_sum,
  output logic [OUT_W-1:0]          quotient,
  output logic                      done
);

  localparam int CW = $clog2(OUT_W + 1);

  logic [SUM_W-1:0] rem_r;
  logic [OUT_W-1:0] low_r;
  logic [OUT_W-1:0] quo_r;
  logic [CW-1:0]    cnt_r;
  logic             done_r;
  logic [SUM_W:0]   trial;
  logic [SUM_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, low_r[OUT_W-1]};
  assign diff  = trial - {1'b0, range_sum};
  assign ge    = trial >= {1'b0, range_sum};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(OUT_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // The upper part of the numerator is already below the range, so only the
  // low bits of the product and the fraction bits produce quotient digits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= scaled_dm[SUM_W+PCT_BITS-1:PCT_BITS];
      low_r <= {scaled_dm[PCT_BITS-1:0], {OUT_FRAC{1'b0}}};
      quo_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      low_r <= {low_r[OUT_W-2:0], 1'b0};
      quo_r <= {quo_r[OUT_W-2:0], ge};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// File: hdl/directional_movement_index_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// directional_movement_index_unit
// Wilder +DI / -DI over a stream of price bars, with bit-serial dividers.
// ----------------------------------------------------------------------------
//  Channel  Ports                        Beat contents (lowest bit first)
//  in       in_tvalid/tready/tdata/tuser tdata: close, high, low; tuser: clear
//  out      out_tvalid/tready/tdata/tuser tdata: index_percent; tuser: valid
//  cfg      cfg_we/cfg_index/cfg_wdata   0: smoothing periods, 1: direction
//
// A bar that ends the warm-up or falls in the smoothing phase makes three passes
// through the serial divide-by-N unit over the S-bit smoothed sums (S is 56 by
// default) and one through the 23-step ratio divider when a ratio is needed;
// other bars use neither divider. Reset is synchronous; it clears the state,
// bar count, previous bar, sums and output valid and restores the default
// configuration. A result waiting at the output stalls only the finishing step
// of the following bar.
// ----------------------------------------------------------------------------
module directional_movement_index_unit import dmi_pkg::*; #(
  parameter int PRICE_BITS      = 32,
  parameter int EXTRA_FRAC_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  // close_price, high_price, low_price, zero padding
  input  logic [((3*PRICE_BITS+7)/8)*8-1:0]          in_tdata,
  // clear_first
  input  logic                                       in_tuser,
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  // index_percent, zero padding
  output logic [OUT_DATA_W-1:0]                      out_tdata,
  // index_valid
  output logic                                       out_tuser,
  input  logic                                       cfg_we,
  input  logic [CFG_IDX_W-1:0]                       cfg_index,
  input  logic [CFG_DATA_W-1:0]                      cfg_wdata
);

  localparam int P      = PRICE_BITS;
  localparam int FULL_W = PRICE_BITS + EXTRA_FRAC_BITS + 8;
  localparam int SW     = (FULL_W > 64) ? 64 : FULL_W;
  localparam int DMW    = SW + PCT_BITS;

  dmi_state_t       state_r, state_nxt;
  logic [N_W-1:0]   periods_r;
  logic             dir_r;
  logic [CNT_W-1:0] bar_count_r;
  logic [P-1:0]     prev_close_r, prev_high_r, prev_low_r;
  logic [P-1:0]     cur_close_r, cur_high_r, cur_low_r;
  logic [SW-1:0]    sum_r [3];
  logic [SW-1:0]    x_r [3];
  dmi_series_t      k_r;
  logic             warm_r, last_r;
  logic [DMW-1:0]   dm100_r;
  logic [OUT_W-1:0] pct_r;
  logic             valid_r;
  logic             out_tvalid_r;
  logic [OUT_W-1:0] out_pct_r;
  logic             out_valid_r;

  logic             div_start, ratio_start, emit_load;
  logic [N_W-1:0]   n_eff;
  logic [CNT_W-1:0] cnt_inc;
  logic             valid_n;
  logic [P-1:0]     dp, dmn, top_p, bot_p, tr_p, dp_k, dmn_k;
  logic [FULL_W-1:0] dp_w, dmn_w, tr_w;
  logic [SW-1:0]    cur_s, cur_x, diff_s, dividend, div_q, applied;
  logic             x_ge_s, div_done, ratio_done;
  logic [SW-1:0]    dm_sel, tr_sum;
  logic [OUT_W-1:0] ratio_q;

  assign n_eff   = (periods_r == '0) ? N_W'(1) : periods_r;
  assign cnt_inc = (bar_count_r == COUNT_MAX) ? bar_count_r : bar_count_r + CNT_W'(1);
  assign valid_n = cnt_inc > {1'b0, n_eff};

  // Movement and true range against the previous bar.
  always_comb begin
    dp    = (cur_high_r > prev_high_r) ? cur_high_r - prev_high_r : '0;
    dmn   = (prev_low_r > cur_low_r) ? prev_low_r - cur_low_r : '0;
    top_p = (cur_high_r > prev_close_r) ? cur_high_r : prev_close_r;
    bot_p = (cur_low_r < prev_close_r) ? cur_low_r : prev_close_r;
    tr_p  = top_p - bot_p;
    dp_k  = (dp > dmn) ? dp : '0;
    dmn_k = (dp > dmn) ? '0 : dmn;
    dp_w  = FULL_W'(dp_k) << EXTRA_FRAC_BITS;
    dmn_w = FULL_W'(dmn_k) << EXTRA_FRAC_BITS;
    tr_w  = FULL_W'(tr_p) << EXTRA_FRAC_BITS;
  end

  always_comb begin
    case (k_r)
      SER_PLUS: begin
        cur_s = sum_r[SER_PLUS];
        cur_x = x_r[SER_PLUS];
      end
      SER_MINUS: begin
        cur_s = sum_r[SER_MINUS];
        cur_x = x_r[SER_MINUS];
      end
      SER_RANGE: begin
        cur_s = sum_r[SER_RANGE];
        cur_x = x_r[SER_RANGE];
      end
      default: begin
        cur_s = '0;
        cur_x = '0;
      end
    endcase
    x_ge_s   = cur_x >= cur_s;
    diff_s   = x_ge_s ? cur_x - cur_s : cur_s - cur_x;
    dividend = warm_r ? cur_s : diff_s;
    applied  = warm_r ? div_q : (x_ge_s ? cur_s + div_q : cur_s - div_q);
  end

  assign dm_sel = dir_r ? sum_r[SER_MINUS] : sum_r[SER_PLUS];
  assign tr_sum = sum_r[SER_RANGE];

  dmi_ndiv #(.SUM_W(SW)) u_ndiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (n_eff),
    .quotient (div_q),
    .done     (div_done)
  );

  dmi_ratio #(.SUM_W(SW)) u_ratio (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (ratio_start),
    .scaled_dm (dm100_r),
    .range_sum (tr_sum),
    .quotient  (ratio_q),
    .done      (ratio_done)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        state_nxt = (bar_count_r == '0) ? ST_UPDATE : ST_ACC;
      end
      ST_ACC: begin
        state_nxt = (warm_r && !last_r) ? ST_UPDATE : ST_DIV_GO;
      end
      ST_DIV_GO: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = (k_r == SER_RANGE) ? ST_UPDATE : ST_DIV_GO;
        end
      end
      ST_UPDATE: begin
        state_nxt = (valid_n && tr_sum != '0 && dm_sel < tr_sum) ? ST_RATIO_GO : ST_EMIT;
      end
      ST_RATIO_GO: begin
        state_nxt = ST_RATIO_WAIT;
      end
      ST_RATIO_WAIT: begin
        if (ratio_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready   = (state_r == ST_IDLE);
    div_start   = (state_r == ST_DIV_GO);
    ratio_start = (state_r == ST_RATIO_GO);
    emit_load   = (state_r == ST_EMIT) && (!out_tvalid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      periods_r         <= RESET_PERIODS;
      dir_r             <= 1'b0;
      bar_count_r       <= '0;
      prev_close_r      <= '0;
      prev_high_r       <= '0;
      prev_low_r        <= '0;
      sum_r[SER_PLUS]   <= '0;
      sum_r[SER_MINUS]  <= '0;
      sum_r[SER_RANGE]  <= '0;
      out_tvalid_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_PERIODS:   periods_r <= cfg_wdata;
          CFG_DIRECTION: dir_r     <= cfg_wdata[0];
          default:       periods_r <= periods_r;
        endcase
      end
      if (emit_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid && in_tuser) begin
            bar_count_r      <= '0;
            prev_close_r     <= '0;
            prev_high_r      <= '0;
            prev_low_r       <= '0;
            sum_r[SER_PLUS]  <= '0;
            sum_r[SER_MINUS] <= '0;
            sum_r[SER_RANGE] <= '0;
          end
        end
        ST_ACC: begin
          if (warm_r) begin
            sum_r[SER_PLUS]  <= sum_r[SER_PLUS] + x_r[SER_PLUS];
            sum_r[SER_MINUS] <= sum_r[SER_MINUS] + x_r[SER_MINUS];
            sum_r[SER_RANGE] <= sum_r[SER_RANGE] + x_r[SER_RANGE];
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            sum_r[k_r] <= applied;
          end
        end
        ST_UPDATE: begin
          bar_count_r  <= cnt_inc;
          prev_close_r <= cur_close_r;
          prev_high_r  <= cur_high_r;
          prev_low_r   <= cur_low_r;
        end
        default: begin
          bar_count_r <= bar_count_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        cur_close_r <= in_tdata[P-1:0];
        cur_high_r  <= in_tdata[2*P-1:P];
        cur_low_r   <= in_tdata[3*P-1:2*P];
      end
      ST_PREP: begin
        x_r[SER_PLUS]  <= dp_w[SW-1:0];
        x_r[SER_MINUS] <= dmn_w[SW-1:0];
        x_r[SER_RANGE] <= tr_w[SW-1:0];
        warm_r         <= bar_count_r <= {1'b0, n_eff};
        last_r         <= bar_count_r == {1'b0, n_eff};
        k_r            <= SER_PLUS;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          case (k_r)
            SER_PLUS:  k_r <= SER_MINUS;
            SER_MINUS: k_r <= SER_RANGE;
            default:   k_r <= SER_PLUS;
          endcase
        end
      end
      ST_UPDATE: begin
        valid_r <= valid_n;
        dm100_r <= DMW'(dm_sel) * DMW'(PCT_SCALE);
        if (!valid_n || tr_sum == '0) begin
          pct_r <= '0;
        end else begin
          pct_r <= FULL_SCALE;
        end
      end
      ST_RATIO_WAIT: begin
        if (ratio_done) begin
          pct_r <= ratio_q;
        end
      end
      ST_EMIT: begin
        if (emit_load) begin
          out_pct_r   <= pct_r;
          out_valid_r <= valid_r;
        end
      end
      default: begin
        pct_r <= pct_r;
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_DATA_W'(out_pct_r);
  assign out_tuser  = out_valid_r;

endmodule

// File: hdl/dmi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmi_checker
// Port-level checks for the directional movement index block, bound to it.
// ----------------------------------------------------------------------------
module dmi_checker import dmi_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Output beat changed while stalled.");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("A beat before warm-up carries a non-zero index.");

  a_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata <= OUT_DATA_W'(FULL_SCALE))
    else $error("Index exceeds one hundred percent.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("A second bar was taken while the first was still in work.");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Output beat offered straight after reset.");

endmodule

bind directional_movement_index_unit dmi_checker u_dmi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
